>>> sv/pid_integral_separation_defines.svh
// Assertion macros for the PID controller with integral separation.
// Used by the sequencer; relies on clk and rst_n in the including module.
`ifndef PID_INTEGRAL_SEPARATION_DEFINES_SVH
`define PID_INTEGRAL_SEPARATION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pis: assertion failed");

// Next-cycle implication, disabled during reset.
`define PIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pis: assertion failed");

`endif

>>> sv/pis_pkg.sv
// Package for the PID controller with integral separation.
// Holds widths, register indexes, control word types and the microcode ROM.
`timescale 1ns / 1ps

package pis_pkg;

    localparam int INTEGRAL_BITS = 32;

    localparam int GAIN_W    = 16;
    localparam int IN_W      = 16;
    localparam int ERR_W     = IN_W + 1;
    localparam int DE_W      = ERR_W + 1;
    localparam int W_FRAC    = 12;
    localparam int WGT_W     = W_FRAC + 1;
    localparam int DIV_STEPS = WGT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int MA_W   = (INTEGRAL_BITS + 1 > 27) ? INTEGRAL_BITS + 1 : 27;
    localparam int MB_W   = 18;
    localparam int PROD_W = MA_W + MB_W;
    localparam int P_LIM_BIT = 50;
    localparam int PCL_W  = P_LIM_BIT + 2;
    localparam int PLO_W  = PCL_W / 2;
    localparam int PX_W   = (PROD_W > PCL_W) ? PROD_W : PCL_W;

    localparam int ACC_W     = 64;
    localparam int FR_SHIFT  = 13;
    localparam int MS_SHIFT  = 25;
    localparam int ACC_SHIFT = 17;
    localparam int DRV_W     = 24;
    localparam int QD_W      = ACC_W - ACC_SHIFT;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOWER = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd4506;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd410;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd82;
    localparam logic [GAIN_W-1:0] BAND_UPPER_RST = 16'd90;
    localparam logic [GAIN_W-1:0] BAND_LOWER_RST = 16'd81;

    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_KP_E  = 3'd1,
        MUL_KD_DE = 3'd2,
        MUL_KI_I  = 3'd3,
        MUL_PLO_W = 3'd4,
        MUL_PHI_W = 3'd5
    } pis_mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD   = 3'd0,
        ACC_INIT   = 3'd1,
        ACC_ADD_LO = 3'd2,
        ACC_ADD_FR = 3'd3,
        ACC_ADD_HI = 3'd4
    } pis_acc_op_t;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_PREP     = 3'd1,
        OP_DIV_INIT = 3'd2,
        OP_DIV_STEP = 3'd3,
        OP_WEIGHT   = 3'd4,
        OP_P_LOAD   = 3'd5,
        OP_FINISH   = 3'd6
    } pis_op_t;

    typedef struct packed {
        pis_op_t      op;
        pis_mul_sel_t mul;
        pis_acc_op_t  acc;
        logic         load_cnt;
        logic         loop;
        logic         last;
    } pis_cw_t;

    typedef struct packed {
        logic    load;
        pis_cw_t cw;
    } pis_ctl_t;

    localparam pis_cw_t CW_NOP = '{
        op: OP_NOP, mul: MUL_NONE, acc: ACC_HOLD, load_cnt: 1'b0, loop: 1'b0, last: 1'b0
    };

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] UPC_PREP     = 4'd0;
    localparam logic [PC_W-1:0] UPC_DIV_INIT = 4'd1;
    localparam logic [PC_W-1:0] UPC_KD_ADD   = 4'd2;
    localparam logic [PC_W-1:0] UPC_DIV_STEP = 4'd3;
    localparam logic [PC_W-1:0] UPC_WEIGHT   = 4'd4;
    localparam logic [PC_W-1:0] UPC_KI_MUL   = 4'd5;
    localparam logic [PC_W-1:0] UPC_P_LOAD   = 4'd6;
    localparam logic [PC_W-1:0] UPC_PLO_MUL  = 4'd7;
    localparam logic [PC_W-1:0] UPC_PHI_MUL  = 4'd8;
    localparam logic [PC_W-1:0] UPC_HI_ADD   = 4'd9;
    localparam logic [PC_W-1:0] UPC_FINISH   = 4'd10;

    function automatic pis_cw_t pis_ucode(input logic [PC_W-1:0] pc);
        pis_cw_t cw;
        cw = CW_NOP;
        case (pc)
            UPC_PREP:
            begin
                cw.op  = OP_PREP;
                cw.mul = MUL_KP_E;
                cw.acc = ACC_INIT;
            end
            UPC_DIV_INIT:
            begin
                cw.op  = OP_DIV_INIT;
                cw.mul = MUL_KD_DE;
                cw.acc = ACC_ADD_FR;
            end
            UPC_KD_ADD:
            begin
                cw.acc      = ACC_ADD_FR;
                cw.load_cnt = 1'b1;
            end
            UPC_DIV_STEP:
            begin
                cw.op   = OP_DIV_STEP;
                cw.loop = 1'b1;
            end
            UPC_WEIGHT:
            begin
                cw.op = OP_WEIGHT;
            end
            UPC_KI_MUL:
            begin
                cw.mul = MUL_KI_I;
            end
            UPC_P_LOAD:
            begin
                cw.op = OP_P_LOAD;
            end
            UPC_PLO_MUL:
            begin
                cw.mul = MUL_PLO_W;
            end
            UPC_PHI_MUL:
            begin
                cw.mul = MUL_PHI_W;
                cw.acc = ACC_ADD_LO;
            end
            UPC_HI_ADD:
            begin
                cw.acc = ACC_ADD_HI;
            end
            UPC_FINISH:
            begin
                cw.op   = OP_FINISH;
                cw.last = 1'b1;
            end
            default:
            begin
                cw = CW_NOP;
            end
        endcase
        return cw;
    endfunction

endpackage

>>> sv/pis_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pis_pkg for operand widths.
`timescale 1ns / 1ps

module pis_mul (
    input  logic                              clk,
    input  logic signed [pis_pkg::MA_W-1:0]   a,
    input  logic signed [pis_pkg::MB_W-1:0]   b,
    output logic signed [pis_pkg::PROD_W-1:0] prod
);
    import pis_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

>>> sv/pis_datapath.sv
// Datapath: configuration registers, controller state, weight divider,
// accumulator and output register. Depends on pis_pkg and pis_mul.
`timescale 1ns / 1ps

module pis_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pis_pkg::pis_ctl_t                    ctl,
    input  logic signed [pis_pkg::IN_W-1:0]      setpoint,
    input  logic signed [pis_pkg::IN_W-1:0]      measured,
    input  logic                                 cfg_we,
    input  logic [pis_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pis_pkg::GAIN_W-1:0]           cfg_data,
    output logic signed [pis_pkg::DRV_W-1:0]     drive,
    output logic                                 clipped
);
    import pis_pkg::*;

    localparam int IS_W = INTEGRAL_BITS + 1;
    localparam logic signed [INTEGRAL_BITS-1:0] I_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    localparam logic signed [INTEGRAL_BITS-1:0] I_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
    localparam logic signed [PX_W-1:0] P_LIM =
        {{(PX_W-P_LIM_BIT-1){1'b0}}, 1'b1, {P_LIM_BIT{1'b0}}};
    localparam logic signed [PX_W-1:0] P_LIM_N = -P_LIM;
    localparam logic signed [DRV_W-1:0] D_MAX = {1'b0, {(DRV_W-1){1'b1}}};
    localparam logic signed [DRV_W-1:0] D_MIN = {1'b1, {(DRV_W-1){1'b0}}};
    localparam logic [WGT_W-1:0] W_FULL = {1'b1, {W_FRAC{1'b0}}};

    logic [GAIN_W-1:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [GAIN_W-1:0] band_upper_reg, band_lower_reg;
    logic signed [INTEGRAL_BITS-1:0] integ_reg;
    logic signed [ERR_W-1:0] e1_reg, e2_reg;

    logic signed [ERR_W-1:0] err_reg;
    logic signed [IN_W-1:0]  ms_reg;
    logic [ERR_W-1:0]        mag_reg;
    logic [ERR_W-1:0]        rem_reg;
    logic [WGT_W-1:0]        quo_reg;
    logic [WGT_W-1:0]        w_reg;
    logic signed [PCL_W-1:0] p_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    clip_reg;
    logic signed [DRV_W-1:0] drive_reg;
    logic                    clipped_reg;

    logic signed [ERR_W-1:0]  err_in;
    logic [ERR_W-1:0]         mag_calc;
    logic [GAIN_W-1:0]        div_d;
    logic [ERR_W:0]           div_t;
    logic                     in_band;
    logic [WGT_W-1:0]         w_calc;
    logic signed [IS_W-1:0]   isum;
    logic                     isat;
    logic signed [INTEGRAL_BITS-1:0] isum_sat;
    logic signed [DE_W-1:0]   de;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_acc;
    logic signed [PX_W-1:0]   px;
    logic signed [PX_W-1:0]   p_cl;
    logic [PLO_W-1:0]         plo;
    logic signed [PCL_W-PLO_W-1:0] phi;
    logic signed [QD_W-1:0]   qd;
    logic [QD_W-DRV_W:0]      qd_hi;
    logic                     dovf;
    logic signed [DRV_W-1:0]  drive_calc;

    assign err_in   = ERR_W'(setpoint) - ERR_W'(measured);
    assign mag_calc = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign div_d    = band_upper_reg - band_lower_reg;
    assign div_t    = {1'b0, rem_reg} - {2'b0, div_d};
    assign in_band  = mag_reg <= {1'b0, band_upper_reg};

    always_comb
    begin
        if (!in_band)
            w_calc = '0;
        else if (mag_reg < {1'b0, band_lower_reg})
            w_calc = W_FULL;
        else if (band_upper_reg > band_lower_reg)
            w_calc = quo_reg;
        else
            w_calc = '0;
    end

    assign isum     = IS_W'(integ_reg) + IS_W'(err_reg);
    assign isat     = isum[IS_W-1] != isum[IS_W-2];
    assign isum_sat = isat ? (isum[IS_W-1] ? I_MIN : I_MAX) : isum[INTEGRAL_BITS-1:0];

    assign de  = DE_W'(err_reg) - DE_W'(e2_reg);
    assign plo = p_reg[PLO_W-1:0];
    assign phi = p_reg[PCL_W-1:PLO_W];

    always_comb
    begin
        case (ctl.cw.mul)
            MUL_KP_E:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'(gain_prop_reg);
            end
            MUL_KD_DE:
            begin
                mul_a = MA_W'(de);
                mul_b = MB_W'(gain_deriv_reg);
            end
            MUL_KI_I:
            begin
                mul_a = MA_W'(integ_reg);
                mul_b = MB_W'(gain_integ_reg);
            end
            MUL_PLO_W:
            begin
                mul_a = MA_W'({1'b0, plo});
                mul_b = MB_W'(w_reg);
            end
            MUL_PHI_W:
            begin
                mul_a = MA_W'(phi);
                mul_b = MB_W'(w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pis_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_acc = ACC_W'(prod);
    assign px       = PX_W'(prod);
    assign p_cl     = (px > P_LIM) ? P_LIM : ((px < P_LIM_N) ? P_LIM_N : px);

    assign qd         = acc_reg[ACC_W-1:ACC_SHIFT];
    assign qd_hi      = qd[QD_W-1:DRV_W-1];
    assign dovf       = !((&qd_hi) || (~|qd_hi));
    assign drive_calc = dovf ? (qd[QD_W-1] ? D_MIN : D_MAX) : qd[DRV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= GAIN_PROP_RST;
            gain_integ_reg <= GAIN_INTEG_RST;
            gain_deriv_reg <= GAIN_DERIV_RST;
            band_upper_reg <= BAND_UPPER_RST;
            band_lower_reg <= BAND_LOWER_RST;
            integ_reg      <= '0;
            e1_reg         <= '0;
            e2_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                    REG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                    REG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                    REG_BAND_UPPER: band_upper_reg <= cfg_data;
                    REG_BAND_LOWER: band_lower_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (ctl.cw.op == OP_WEIGHT && in_band)
                integ_reg <= isum_sat;
            if (ctl.cw.op == OP_FINISH)
            begin
                e2_reg <= e1_reg;
                e1_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            err_reg  <= err_in;
            ms_reg   <= measured;
            clip_reg <= 1'b0;
        end

        case (ctl.cw.op)
            OP_PREP:
            begin
                mag_reg <= mag_calc;
            end
            OP_DIV_INIT:
            begin
                rem_reg <= {1'b0, band_upper_reg} - mag_reg;
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                if (!div_t[ERR_W])
                begin
                    rem_reg <= {div_t[GAIN_W-1:0], 1'b0};
                    quo_reg <= {quo_reg[WGT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[GAIN_W-1:0], 1'b0};
                    quo_reg <= {quo_reg[WGT_W-2:0], 1'b0};
                end
            end
            OP_WEIGHT:
            begin
                w_reg <= w_calc;
                if (in_band && isat)
                    clip_reg <= 1'b1;
            end
            OP_P_LOAD:
            begin
                p_reg <= p_cl[PCL_W-1:0];
            end
            OP_FINISH:
            begin
                drive_reg   <= drive_calc;
                clipped_reg <= clip_reg | dovf;
            end
            default:
            begin
            end
        endcase

        case (ctl.cw.acc)
            ACC_INIT:   acc_reg <= ACC_W'(ms_reg) <<< MS_SHIFT;
            ACC_ADD_LO: acc_reg <= acc_reg + prod_acc;
            ACC_ADD_FR: acc_reg <= acc_reg + (prod_acc <<< FR_SHIFT);
            ACC_ADD_HI: acc_reg <= acc_reg + (prod_acc <<< PLO_W);
            default:    ;
        endcase
    end

    assign drive   = drive_reg;
    assign clipped = clipped_reg;

endmodule

>>> sv/pis_seq.sv
// Microcode sequencer: step counter, loop counter, ROM fetch and handshakes.
// Depends on pis_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "pid_integral_separation_defines.svh"

module pis_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pis_pkg::pis_ctl_t ctl
);
    import pis_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } pis_state_t;

    pis_state_t       state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    pis_cw_t cw_raw;
    logic    running;
    logic    out_free;
    logic    fire;
    logic    accept;

    assign cw_raw   = pis_ucode(pc_reg);
    assign running  = state_reg == ST_RUN;
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = running && cw_raw.last && out_free;
    assign accept   = in_valid && state_reg == ST_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        ctl.load       = accept;
        ctl.cw         = CW_NOP;

        if (out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                end
            end
            ST_RUN:
            begin
                ctl.cw = cw_raw;
                if (cw_raw.load_cnt)
                    cnt_next = CNT_W'(DIV_STEPS - 1);
                if (cw_raw.loop && cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (cw_raw.last)
                begin
                    if (fire)
                    begin
                        state_next     = ST_IDLE;
                        pc_next        = '0;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        ctl.cw.op = OP_NOP;
                    end
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pc_next    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

    `PIS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == ST_RUN && pc_reg == '0)
    `PIS_ASSERT_IMP(a_idle_clean, state_reg == ST_IDLE, pc_reg == '0 && cnt_reg == '0)
    `PIS_ASSERT_IMP(a_cnt_in_loop, cnt_reg != '0, running && pc_reg == UPC_DIV_STEP)
    `PIS_ASSERT_NEXT(a_finish_shows, ctl.cw.op == OP_FINISH, out_valid_reg && state_reg == ST_IDLE)

endmodule

>>> sv/pid_integral_separation.sv
// Speed PID controller with variable-speed integration. A microcoded
// sequencer runs 11 steps on one shared 33x18 multiplier, and the integral
// weight comes from a 13-step restoring divider. The result sits in an
// output register, so a new input is taken while it waits; if it is still
// not taken when the next result is ready, the sequencer holds at its last
// step.
// Depends on pis_pkg, pis_seq and pis_datapath.
`timescale 1ns / 1ps

module pid_integral_separation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [pis_pkg::IN_W-1:0]  setpoint,
    input  logic signed [pis_pkg::IN_W-1:0]  measured,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [pis_pkg::DRV_W-1:0] drive,
    output logic                             clipped,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pis_pkg::GAIN_W-1:0]       cfg_data
);
    import pis_pkg::*;

    pis_ctl_t ctl;

    assign cfg_ready = 1'b1;

    pis_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    pis_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .setpoint  (setpoint),
        .measured  (measured),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .drive     (drive),
        .clipped   (clipped)
    );

endmodule
